// ===== rtl/fp16_softmax_sum_exp_core_assert.svh =====
// Assertion macros for the fp16 softmax exp/sum core.
// Uses the clk and rst_n names of the including module.
`ifndef FP16_SOFTMAX_SUM_EXP_CORE_ASSERT_SVH
`define FP16_SOFTMAX_SUM_EXP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFX_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFX_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfx_pkg.sv =====
// Package for the fp16 softmax exp/sum core: word types, fp16 constants,
// sequencer codes. No dependencies.
package sfx_pkg;

    localparam int LANES       = 8;
    localparam int FOLD_ROUNDS = $clog2(LANES);
    localparam int ROUND_W     = (FOLD_ROUNDS > 1) ? $clog2(FOLD_ROUNDS) : 1;

    localparam logic [15:0] H_ZERO     = 16'h0000;
    localparam logic [15:0] H_ONE      = 16'h3C00;
    localparam logic [15:0] H_NEG_ZERO = 16'h8000;
    localparam logic [15:0] H_QNAN     = 16'h7E00;
    localparam logic [15:0] H_LOWER    = 16'hC95F;
    localparam logic [15:0] H_BIAS     = 16'h6600;
    localparam logic [15:0] H_NEG_BIAS = 16'hE600;
    localparam logic [15:0] H_INV_LN2  = 16'h3DC5;
    localparam logic [15:0] H_LN2_HI   = 16'hB98B;
    localparam logic [15:0] H_LN2_MID  = 16'h8C85;
    localparam logic [15:0] H_LN2_LO   = 16'h8004;
    localparam logic [15:0] H_C6       = 16'h15B0;
    localparam logic [15:0] H_C5       = 16'h2044;
    localparam logic [15:0] H_C4       = 16'h2955;
    localparam logic [15:0] H_C3       = 16'h3155;
    localparam logic [15:0] H_C2       = 16'h3800;

    typedef struct packed {
        logic [15:0] value_0;
        logic [15:0] value_1;
        logic [15:0] value_2;
        logic [15:0] value_3;
        logic [15:0] value_4;
        logic [15:0] value_5;
        logic [15:0] value_6;
        logic [15:0] value_7;
        logic [15:0] neg_max;
        logic [3:0]  lane_count;
        logic        last_item;
    } in_word_t;

    typedef struct packed {
        logic [15:0] exp_0;
        logic [15:0] exp_1;
        logic [15:0] exp_2;
        logic [15:0] exp_3;
        logic [15:0] exp_4;
        logic [15:0] exp_5;
        logic [15:0] exp_6;
        logic [15:0] exp_7;
        logic [15:0] row_sum;
        logic        end_of_row;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_ADD,
        ST_BIAS,
        ST_UNBIAS,
        ST_RED_HI,
        ST_RED_MID,
        ST_RED_LO,
        ST_POLY6,
        ST_POLY5,
        ST_POLY4,
        ST_POLY3,
        ST_POLY2,
        ST_POLY1,
        ST_SCALE,
        ST_ACCUM,
        ST_FOLD
    } step_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXP,
        S_FOLD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  en;
        logic  clear;
        step_t step;
    } lane_ctrl_t;

endpackage

// ===== rtl/sfx_fma.sv =====
// Combinational fp16 fused multiply-add, round to nearest even, subnormals kept.
// Depends on sfx_pkg for fp16 constants.
module sfx_fma (
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic [15:0] c,
    output logic [15:0] y
);

    // exact fixed-point window, LSB weight 2^-48
    localparam int W = 82;

    logic [4:0]   ea_f, eb_f, ec_f;
    logic [10:0]  ma, mb, mc;
    logic [5:0]   ka, kb, kc;
    logic         sp, sc;
    logic         a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero;
    logic [21:0]  prod;
    logic [5:0]   sh_a, sh_c;
    logic [W-1:0] av, cv, mag, low_mask;
    logic         rs;
    logic [6:0]   len, s, fld;
    logic [W-1:0] shifted;
    logic [11:0]  q, qr;
    logic [10:0]  qn;
    logic         guard, sticky, rnd;

    assign ea_f = a[14:10];
    assign eb_f = b[14:10];
    assign ec_f = c[14:10];
    assign ma   = {ea_f != 5'd0, a[9:0]};
    assign mb   = {eb_f != 5'd0, b[9:0]};
    assign mc   = {ec_f != 5'd0, c[9:0]};
    assign ka   = (ea_f == 5'd0) ? 6'd1 : {1'b0, ea_f};
    assign kb   = (eb_f == 5'd0) ? 6'd1 : {1'b0, eb_f};
    assign kc   = (ec_f == 5'd0) ? 6'd1 : {1'b0, ec_f};
    assign sp   = a[15] ^ b[15];
    assign sc   = c[15];

    assign a_nan  = (ea_f == 5'h1F) && (a[9:0] != 10'd0);
    assign b_nan  = (eb_f == 5'h1F) && (b[9:0] != 10'd0);
    assign c_nan  = (ec_f == 5'h1F) && (c[9:0] != 10'd0);
    assign a_inf  = (a[14:0] == 15'h7C00);
    assign b_inf  = (b[14:0] == 15'h7C00);
    assign c_inf  = (c[14:0] == 15'h7C00);
    assign a_zero = (a[14:0] == 15'd0);
    assign b_zero = (b[14:0] == 15'd0);

    assign prod = 22'(ma) * 22'(mb);
    assign sh_a = ka + kb - 6'd2;
    assign sh_c = kc + 6'd23;
    assign av   = W'(prod) << sh_a;
    assign cv   = W'(mc) << sh_c;

    always_comb
    begin
        if (sp == sc)
        begin
            mag = av + cv;
            rs  = sp;
        end
        else if (av >= cv)
        begin
            mag = av - cv;
            rs  = sp;
        end
        else
        begin
            mag = cv - av;
            rs  = sc;
        end
    end

    always_comb
    begin
        len = 7'd0;
        for (int i = 0; i < W; i++)
        begin
            if (mag[i])
            begin
                len = 7'(i + 1);
            end
        end
    end

    // LSB position of the kept 11 bits, floored at the subnormal weight 2^-24
    assign s        = (len > 7'd35) ? (len - 7'd11) : 7'd24;
    assign shifted  = mag >> s;
    assign q        = {1'b0, shifted[10:0]};
    assign guard    = mag[s - 7'd1];
    assign low_mask = (W'(1) << (s - 7'd1)) - W'(1);
    assign sticky   = |(mag & low_mask);
    assign rnd      = guard && (sticky || q[0]);
    assign qr       = q + 12'(rnd);
    assign qn       = qr[11] ? qr[11:1] : qr[10:0];
    assign fld      = qr[11] ? (s - 7'd22) : (s - 7'd23);

    always_comb
    begin
        priority if (a_nan || b_nan || c_nan)
        begin
            y = sfx_pkg::H_QNAN;
        end
        else if (a_inf || b_inf)
        begin
            if (a_zero || b_zero || (c_inf && (sc != sp)))
            begin
                y = sfx_pkg::H_QNAN;
            end
            else
            begin
                y = {sp, 15'h7C00};
            end
        end
        else if (c_inf)
        begin
            y = c;
        end
        else if (len == 7'd0)
        begin
            // exact zero: negative only when both terms are negative zeros
            y = {(prod == 22'd0) && (mc == 11'd0) && sp && sc, 15'd0};
        end
        else if (qn < 11'h400)
        begin
            y = {rs, 5'd0, qn[9:0]};
        end
        else if (fld > 7'd30)
        begin
            y = {rs, 15'h7C00};
        end
        else
        begin
            y = {rs, fld[4:0], qn[9:0]};
        end
    end

endmodule

// ===== rtl/sfx_lane.sv =====
// One exp lane: range reduction, polynomial, scaling and running sum, all
// through one shared fp16 FMA. Depends on sfx_pkg and sfx_fma.
module sfx_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  sfx_pkg::lane_ctrl_t ctrl,
    input  logic               lane_valid,
    input  logic               fold_en,
    input  logic [15:0]        value,
    input  logic [15:0]        neg_max,
    input  logic [15:0]        partner,
    output logic [15:0]        exp_value,
    output logic [15:0]        sum_value
);

    logic [15:0] c_reg, biased_reg, m_reg, r_reg, p_reg, sum_reg;
    logic [15:0] op_a, op_b, op_c, fma_y, clamped, scale;

    sfx_fma u_fma (
        .a (op_a),
        .b (op_b),
        .c (op_c),
        .y (fma_y)
    );

    // 2^m placed in the exponent field, wrapping modulo 2^16
    assign scale = {biased_reg[5:0], 10'd0} + sfx_pkg::H_ONE;

    // clamp below at -15.5 ln2; NaN goes quiet
    always_comb
    begin
        priority if ((fma_y[14:10] == 5'h1F) && (fma_y[9:0] != 10'd0))
        begin
            clamped = sfx_pkg::H_QNAN;
        end
        else if (fma_y[15] && (fma_y[14:0] > sfx_pkg::H_LOWER[14:0]))
        begin
            clamped = sfx_pkg::H_LOWER;
        end
        else
        begin
            clamped = fma_y;
        end
    end

    always_comb
    begin
        unique case (ctrl.step)
            sfx_pkg::ST_ADD:     begin op_a = value;      op_b = sfx_pkg::H_ONE;
                                       op_c = neg_max; end
            sfx_pkg::ST_BIAS:    begin op_a = c_reg;      op_b = sfx_pkg::H_INV_LN2;
                                       op_c = sfx_pkg::H_BIAS; end
            sfx_pkg::ST_UNBIAS:  begin op_a = biased_reg; op_b = sfx_pkg::H_ONE;
                                       op_c = sfx_pkg::H_NEG_BIAS; end
            sfx_pkg::ST_RED_HI:  begin op_a = m_reg;      op_b = sfx_pkg::H_LN2_HI;
                                       op_c = c_reg; end
            sfx_pkg::ST_RED_MID: begin op_a = m_reg;      op_b = sfx_pkg::H_LN2_MID;
                                       op_c = r_reg; end
            sfx_pkg::ST_RED_LO:  begin op_a = m_reg;      op_b = sfx_pkg::H_LN2_LO;
                                       op_c = r_reg; end
            sfx_pkg::ST_POLY6:   begin op_a = sfx_pkg::H_C6; op_b = r_reg;
                                       op_c = sfx_pkg::H_C5; end
            sfx_pkg::ST_POLY5:   begin op_a = p_reg; op_b = r_reg; op_c = sfx_pkg::H_C4; end
            sfx_pkg::ST_POLY4:   begin op_a = p_reg; op_b = r_reg; op_c = sfx_pkg::H_C3; end
            sfx_pkg::ST_POLY3:   begin op_a = p_reg; op_b = r_reg; op_c = sfx_pkg::H_C2; end
            sfx_pkg::ST_POLY2:   begin op_a = p_reg; op_b = r_reg; op_c = sfx_pkg::H_ONE; end
            sfx_pkg::ST_POLY1:   begin op_a = p_reg; op_b = r_reg; op_c = sfx_pkg::H_ONE; end
            sfx_pkg::ST_SCALE:   begin op_a = p_reg; op_b = scale;
                                       op_c = sfx_pkg::H_NEG_ZERO; end
            sfx_pkg::ST_ACCUM:   begin op_a = sum_reg; op_b = sfx_pkg::H_ONE; op_c = p_reg; end
            sfx_pkg::ST_FOLD:    begin op_a = sum_reg; op_b = sfx_pkg::H_ONE; op_c = partner; end
            default:             begin op_a = sfx_pkg::H_ZERO; op_b = sfx_pkg::H_ZERO;
                                       op_c = sfx_pkg::H_ZERO; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            case (ctrl.step)
                sfx_pkg::ST_ADD:     c_reg      <= clamped;
                sfx_pkg::ST_BIAS:    biased_reg <= fma_y;
                sfx_pkg::ST_UNBIAS:  m_reg      <= fma_y;
                sfx_pkg::ST_RED_HI,
                sfx_pkg::ST_RED_MID,
                sfx_pkg::ST_RED_LO:  r_reg      <= fma_y;
                sfx_pkg::ST_POLY6,
                sfx_pkg::ST_POLY5,
                sfx_pkg::ST_POLY4,
                sfx_pkg::ST_POLY3,
                sfx_pkg::ST_POLY2,
                sfx_pkg::ST_POLY1:   p_reg      <= fma_y;
                sfx_pkg::ST_SCALE:   p_reg      <= lane_valid ? fma_y : sfx_pkg::H_ZERO;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= sfx_pkg::H_ZERO;
        end
        else if (ctrl.clear)
        begin
            sum_reg <= sfx_pkg::H_ZERO;
        end
        else if (ctrl.en && ((ctrl.step == sfx_pkg::ST_ACCUM)
                             || ((ctrl.step == sfx_pkg::ST_FOLD) && fold_en)))
        begin
            sum_reg <= fma_y;
        end
    end

    assign exp_value = p_reg;
    assign sum_value = sum_reg;

endmodule

// ===== rtl/sfx_merge.sv =====
// Halving fold network over the lane sums: picks each lane's partner per
// round and which lanes write. No dependencies.
module sfx_merge #(
    parameter int LANES = 8
) (
    input  logic [LANES-1:0][15:0] sums,
    input  logic [((($clog2(LANES)) > 1) ? $clog2($clog2(LANES)) : 1)-1:0] round,
    output logic [LANES-1:0][15:0] partner,
    output logic [LANES-1:0]       fold_en,
    output logic [15:0]            row_sum
);

    localparam int ROUNDS = $clog2(LANES);
    localparam int RW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int IW     = (LANES > 1) ? $clog2(LANES) : 1;

    // values still live after r halvings
    function automatic int fold_size(input int r);
        int n;
        n = LANES;
        for (int k = 0; k < r; k++)
        begin
            n = (n + 1) / 2;
        end
        return n;
    endfunction

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        always_comb
        begin
            partner[i] = 16'd0;
            fold_en[i] = 1'b0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                if ((round == RW'(r)) && (i < fold_size(r) / 2))
                begin
                    partner[i] = sums[IW'(i + (fold_size(r) + 1) / 2)];
                    fold_en[i] = 1'b1;
                end
            end
        end
    end

    assign row_sum = sums[0];

endmodule

// ===== rtl/fp16_softmax_sum_exp_core.sv =====
// fp16 softmax exp/sum core, top level: sequencer, lanes, fold, output register.
// Depends on sfx_pkg, sfx_lane, sfx_merge and the assertion macro header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one word per row
//   slice: eight fp16 values, the row's negated maximum, the number of live
//   lanes and a last-of-row flag. Output channel (out_valid / out_stall /
//   out_word) returns the eight exp values and, on the last word of a row,
//   the fp16 row sum with end_of_row set.
//   Each lane runs its exp through one shared FMA, one operation a cycle:
//   the exp and accumulate steps (ST_ADD to ST_ACCUM), plus the fold rounds
//   on the row's last word. A result, if any, loads in S_DONE after these;
//   a new word is taken only back in S_IDLE. That FMA chain sets the rate.
//   With emit_values cleared only last words produce a result.
//   The output register holds a finished word while the receiver stalls;
//   the core then waits before loading the next one.
//   Reset clears the lane sums and the sequencer and sets emit_values.
//   Write cfg_write_data to emit_values only while the core is idle.
`include "fp16_softmax_sum_exp_core_assert.svh"

module fp16_softmax_sum_exp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sfx_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output sfx_pkg::out_word_t out_word,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data
);

    localparam int LANES = sfx_pkg::LANES;

    sfx_pkg::state_t    state_reg, state_next;
    sfx_pkg::step_t     step_reg;
    logic [sfx_pkg::ROUND_W-1:0] round_reg;
    sfx_pkg::in_word_t  item_reg;
    sfx_pkg::out_word_t out_word_reg, out_word_next;
    logic               out_valid_reg;
    logic               emit_reg;

    sfx_pkg::lane_ctrl_t     lane_ctrl;
    logic [LANES-1:0][15:0]  lane_value, lane_exp, lane_sum, partner;
    logic [LANES-1:0]        fold_en;
    logic [15:0]             row_sum;
    logic                    accept, out_free, need_result, load;

    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign need_result = emit_reg || item_reg.last_item;

    // spread the held word over the lanes
    always_comb
    begin
        lane_value[0] = item_reg.value_0;
        lane_value[1] = item_reg.value_1;
        lane_value[2] = item_reg.value_2;
        lane_value[3] = item_reg.value_3;
        lane_value[4] = item_reg.value_4;
        lane_value[5] = item_reg.value_5;
        lane_value[6] = item_reg.value_6;
        lane_value[7] = item_reg.value_7;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        sfx_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .lane_valid (item_reg.lane_count > 4'(i)),
            .fold_en    (fold_en[i]),
            .value      (lane_value[i]),
            .neg_max    (item_reg.neg_max),
            .partner    (partner[i]),
            .exp_value  (lane_exp[i]),
            .sum_value  (lane_sum[i])
        );
    end

    sfx_merge #(
        .LANES (LANES)
    ) u_merge (
        .sums    (lane_sum),
        .round   (round_reg),
        .partner (partner),
        .fold_en (fold_en),
        .row_sum (row_sum)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfx_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfx_pkg::S_EXP;
                end
            end
            sfx_pkg::S_EXP:
            begin
                if (step_reg == sfx_pkg::ST_ACCUM)
                begin
                    state_next = (item_reg.last_item && (sfx_pkg::FOLD_ROUNDS > 0))
                               ? sfx_pkg::S_FOLD : sfx_pkg::S_DONE;
                end
            end
            sfx_pkg::S_FOLD:
            begin
                if (round_reg == sfx_pkg::ROUND_W'(sfx_pkg::FOLD_ROUNDS - 1))
                begin
                    state_next = sfx_pkg::S_DONE;
                end
            end
            sfx_pkg::S_DONE:
            begin
                if (!need_result || out_free)
                begin
                    state_next = sfx_pkg::S_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall        = (state_reg != sfx_pkg::S_IDLE);
        load            = (state_reg == sfx_pkg::S_DONE) && need_result && out_free;
        lane_ctrl.en    = (state_reg == sfx_pkg::S_EXP) || (state_reg == sfx_pkg::S_FOLD);
        lane_ctrl.step  = (state_reg == sfx_pkg::S_FOLD) ? sfx_pkg::ST_FOLD : step_reg;
        lane_ctrl.clear = load && item_reg.last_item;
    end

    always_comb
    begin
        out_word_next.exp_0      = emit_reg ? lane_exp[0] : sfx_pkg::H_ZERO;
        out_word_next.exp_1      = emit_reg ? lane_exp[1] : sfx_pkg::H_ZERO;
        out_word_next.exp_2      = emit_reg ? lane_exp[2] : sfx_pkg::H_ZERO;
        out_word_next.exp_3      = emit_reg ? lane_exp[3] : sfx_pkg::H_ZERO;
        out_word_next.exp_4      = emit_reg ? lane_exp[4] : sfx_pkg::H_ZERO;
        out_word_next.exp_5      = emit_reg ? lane_exp[5] : sfx_pkg::H_ZERO;
        out_word_next.exp_6      = emit_reg ? lane_exp[6] : sfx_pkg::H_ZERO;
        out_word_next.exp_7      = emit_reg ? lane_exp[7] : sfx_pkg::H_ZERO;
        out_word_next.row_sum    = item_reg.last_item ? row_sum : sfx_pkg::H_ZERO;
        out_word_next.end_of_row = item_reg.last_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfx_pkg::S_IDLE;
            step_reg      <= sfx_pkg::ST_ADD;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            emit_reg      <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                emit_reg <= cfg_write_data;
            end
            // advance the exp step and fold round counters
            if (accept)
            begin
                step_reg  <= sfx_pkg::ST_ADD;
                round_reg <= '0;
            end
            else
            begin
                if ((state_reg == sfx_pkg::S_EXP) && (step_reg != sfx_pkg::ST_ACCUM))
                begin
                    step_reg <= sfx_pkg::step_t'(step_reg + 4'd1);
                end
                if (state_reg == sfx_pkg::S_FOLD)
                begin
                    round_reg <= round_reg + sfx_pkg::ROUND_W'(1);
                end
            end
            // hold a word until taken, drop it once accepted
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
        end
        if (load)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `SFX_ASSERT_NEXT(a_accept_starts, accept,
        (state_reg == sfx_pkg::S_EXP) && (step_reg == sfx_pkg::ST_ADD),
        "accepted word did not start the exp sequence")
    `SFX_ASSERT_NOW(a_fold_only_last, state_reg == sfx_pkg::S_FOLD, item_reg.last_item,
        "fold running on a word that does not end a row")
    `SFX_ASSERT_NOW(a_sum_only_at_end, out_valid_reg && !out_word_reg.end_of_row,
        out_word_reg.row_sum == sfx_pkg::H_ZERO,
        "row sum nonzero on a word that does not end a row")
    `SFX_ASSERT_NEXT(a_sums_cleared, load && item_reg.last_item, lane_sum == '0,
        "lane sums not cleared after row end")

endmodule

// ===== tb/sv/sfx_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the fp16 softmax exp/sum core: watches both channels and the
// config port, predicts each output word in fp16 arithmetic and compares. Uses sfx_pkg.
module sfx_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  sfx_pkg::in_word_t  in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  sfx_pkg::out_word_t out_word,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    output int                 fail_count,
    output int                 words_pending
);

    sfx_pkg::out_word_t expected_words[$];
    logic [15:0] row_acc[sfx_pkg::LANES];
    logic        emit_on;

    function automatic int bit_length(logic [63:0] v);
        int n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v >>= 1;
        end
        return n;
    endfunction

    function automatic void split_half(input logic [15:0] x, output logic [63:0] sig,
                                       output int e);
        if (x[14:10] == 0)
        begin
            sig = {54'd0, x[9:0]};
            e = -24;
        end
        else
        begin
            sig = {53'd0, 1'b1, x[9:0]};
            e = int'(x[14:10]) - 25;
        end
    endfunction

    function automatic logic is_nan(logic [15:0] x);
        return x[14:10] == 5'h1F && x[9:0] != 0;
    endfunction

    function automatic logic is_inf(logic [15:0] x);
        return x[14:0] == 15'h7C00;
    endfunction

    function automatic logic is_zero(logic [15:0] x);
        return x[14:0] == 0;
    endfunction

    // Round (mag + sticky fraction) * 2^e to nearest-even fp16.
    function automatic logic [15:0] round_half(logic sign, logic [63:0] mag, int e,
                                               logic sticky);
        int s, ex, field;
        logic [63:0] q, rem, half;
        if (mag == 0)
            return {sign, 15'd0};
        s = bit_length(mag) - 11;
        if (e + s < -24)
            s = -24 - e;
        if (s <= 0)
            q = mag << (-s);
        else if (s >= 64)
            q = 0;
        else
        begin
            rem = mag & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            q = mag >> s;
            if (rem > half || (rem == half && (sticky || q[0])))
                q++;
        end
        ex = e + s;
        if ((q >> 11) != 0)
        begin
            q >>= 1;
            ex++;
        end
        if (q < 64'h400)
            return {sign, q[14:0]};
        field = ex + 25;
        if (field > 30)
            return {sign, 15'h7C00};
        return {sign, field[4:0], q[9:0]};
    endfunction

    function automatic logic [15:0] exact_sum(logic s1, logic [63:0] m1, int e1,
                                              logic s2, logic [63:0] m2, int e2);
        int sh, d;
        logic [63:0] y, mag, tm;
        int te;
        logic ts, st;
        sh = 60 - bit_length(m1);
        m1 <<= sh;
        e1 -= sh;
        sh = 60 - bit_length(m2);
        m2 <<= sh;
        e2 -= sh;
        if (e1 < e2 || (e1 == e2 && m1 < m2))
        begin
            tm = m1; te = e1; ts = s1;
            m1 = m2; e1 = e2; s1 = s2;
            m2 = tm; e2 = te; s2 = ts;
        end
        d = e1 - e2;
        if (d >= 63)
        begin
            y = 0;
            st = 1'b1;
        end
        else
        begin
            y = m2 >> d;
            st = (m2 & ((64'd1 << d) - 1)) != 0;
        end
        if (s1 == s2)
            mag = m1 + y;
        else
        begin
            mag = m1 - y;
            if (st)
                mag -= 1;
            if (mag == 0 && !st)
                return 16'h0000;
        end
        return round_half(s1, mag, e1, st);
    endfunction

    // Fused a*b + c with one rounding.
    function automatic logic [15:0] fused_madd(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c);
        logic sp, sc;
        logic [63:0] ma, mb, mc, mp;
        int ea, eb, ec;
        sp = a[15] ^ b[15];
        sc = c[15];
        if (is_nan(a) || is_nan(b) || is_nan(c))
            return sfx_pkg::H_QNAN;
        if (is_inf(a) || is_inf(b))
        begin
            if (is_zero(a) || is_zero(b))
                return sfx_pkg::H_QNAN;
            if (is_inf(c) && sc != sp)
                return sfx_pkg::H_QNAN;
            return {sp, 15'h7C00};
        end
        if (is_inf(c))
            return c;
        split_half(a, ma, ea);
        split_half(b, mb, eb);
        split_half(c, mc, ec);
        mp = ma * mb;
        if (mp == 0)
        begin
            if (mc == 0)
                return {sp & sc, 15'd0};
            return c;
        end
        if (mc == 0)
            return round_half(sp, mp, ea + eb, 1'b0);
        return exact_sum(sp, mp, ea + eb, sc, mc, ec);
    endfunction

    function automatic logic [15:0] half_add(logic [15:0] a, logic [15:0] b);
        return fused_madd(a, sfx_pkg::H_ONE, b);
    endfunction

    function automatic logic [15:0] half_max(logic [15:0] a, logic [15:0] b);
        int va, vb;
        if (is_nan(a) || is_nan(b))
            return sfx_pkg::H_QNAN;
        va = a[15] ? -int'(a[14:0]) : int'(a[14:0]);
        vb = b[15] ? -int'(b[14:0]) : int'(b[14:0]);
        if (va > vb)
            return a;
        if (vb > va)
            return b;
        return a & b;
    endfunction

    function automatic logic [15:0] shifted_exp(logic [15:0] x, logic [15:0] negmax);
        logic [15:0] t, biased, m, r, p, scale;
        t = half_max(half_add(x, negmax), sfx_pkg::H_LOWER);
        biased = fused_madd(t, sfx_pkg::H_INV_LN2, sfx_pkg::H_BIAS);
        m = half_add(biased, sfx_pkg::H_NEG_BIAS);
        r = fused_madd(m, sfx_pkg::H_LN2_HI, t);
        r = fused_madd(m, sfx_pkg::H_LN2_MID, r);
        r = fused_madd(m, sfx_pkg::H_LN2_LO, r);
        scale = (biased << 10) + sfx_pkg::H_ONE;
        p = fused_madd(sfx_pkg::H_C6, r, sfx_pkg::H_C5);
        p = fused_madd(p, r, sfx_pkg::H_C4);
        p = fused_madd(p, r, sfx_pkg::H_C3);
        p = fused_madd(p, r, sfx_pkg::H_C2);
        p = fused_madd(p, r, sfx_pkg::H_ONE);
        p = fused_madd(p, r, sfx_pkg::H_ONE);
        return fused_madd(p, scale, sfx_pkg::H_NEG_ZERO);
    endfunction

    task automatic predict_word(sfx_pkg::in_word_t w);
        logic [15:0] ex[sfx_pkg::LANES];
        logic [15:0] fold[sfx_pkg::LANES];
        logic [15:0] total;
        int live, n, h;
        sfx_pkg::out_word_t res;
        live = (w.lane_count > sfx_pkg::LANES) ? sfx_pkg::LANES : w.lane_count;
        total = 16'h0000;
        for (int i = 0; i < sfx_pkg::LANES; i++)
        begin
            ex[i] = (i < live) ? shifted_exp(w[148 - 16 * i -: 16], w.neg_max) : 16'h0000;
            row_acc[i] = half_add(row_acc[i], ex[i]);
        end
        if (w.last_item)
        begin
            fold = row_acc;
            n = sfx_pkg::LANES;
            while (n > 1)
            begin
                h = (n + 1) / 2;
                for (int i = 0; i < n / 2; i++)
                    fold[i] = half_add(fold[i], fold[i + h]);
                n = h;
            end
            total = fold[0];
            foreach (row_acc[i])
                row_acc[i] = 16'h0000;
        end
        if (emit_on || w.last_item)
        begin
            for (int i = 0; i < sfx_pkg::LANES; i++)
                res[144 - 16 * i -: 16] = emit_on ? ex[i] : 16'h0000;
            res.row_sum = total;
            res.end_of_row = w.last_item;
            expected_words.push_back(res);
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_word(sfx_pkg::out_word_t got);
        sfx_pkg::out_word_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected output word %h", $realtime, got);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        for (int i = 0; i < sfx_pkg::LANES; i++)
            if (got[144 - 16 * i -: 16] !== want[144 - 16 * i -: 16])
                report_mismatch($sformatf("exp_%0d", i), got[144 - 16 * i -: 16],
                                want[144 - 16 * i -: 16]);
        if (got.row_sum !== want.row_sum)
            report_mismatch("row_sum", got.row_sum, want.row_sum);
        if (got.end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", 16'(got.end_of_row), 16'(want.end_of_row));
    endtask

    initial
    begin
        fail_count = 0;
        words_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (row_acc[i])
                row_acc[i] = 16'h0000;
            emit_on = 1'b1;
            expected_words.delete();
            words_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word(out_word);
            if (in_valid && !in_stall)
                predict_word(in_word);
            if (cfg_write_en)
                emit_on = cfg_write_data;
            words_pending = expected_words.size();
        end
    end

    // Anything still queued at the end is waited on from the top via words_pending.
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the fp16 softmax exp/sum core testbench: clock, reset, stimulus and verdict.
// Depends on sfx_pkg, the core and sfx_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 40;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    sfx_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    sfx_pkg::out_word_t out_word;
    logic               cfg_write_en;
    logic               cfg_write_data;
    int                 fail_count;
    int                 words_pending;

    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_req;
    int        rx_hold_left;
    int        cycle_count;

    fp16_softmax_sum_exp_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    sfx_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stall, plus a long hold-off when asked for one.
    initial
    begin
        rx_hold_req = 0;
        rx_hold_left = 0;
    end

    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Watchdog: a hung core ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Lane value in a useful range: roughly 1/64 .. 32, random sign.
    function automatic logic [15:0] typical_half();
        return {1'($urandom_range(1)), 5'($urandom_range(9, 19)), 10'($urandom)};
    endfunction

    function automatic sfx_pkg::in_word_t make_word(logic [15:0] v, logic [15:0] negmax,
                                                    logic [3:0] lanes, logic last);
        sfx_pkg::in_word_t w;
        for (int i = 0; i < sfx_pkg::LANES; i++)
            w[148 - 16 * i -: 16] = v;
        w.neg_max = negmax;
        w.lane_count = lanes;
        w.last_item = last;
        return w;
    endfunction

    // Offer one word and hold it until the core takes it.
    task automatic send_word(sfx_pkg::in_word_t w);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(posedge clk);
        // A non-last word with emission off leaves no trace in the queue.
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_emit(logic val);
        cfg_write_en <= 1'b1;
        cfg_write_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Rows of well-formed words, with some raw bit noise mixed in.
    task automatic random_rows(int count);
        int left, row_len;
        sfx_pkg::in_word_t w;
        logic [15:0] negmax;
        left = count;
        while (left > 0)
        begin
            row_len = $urandom_range(1, 6);
            negmax = {1'b1, 5'($urandom_range(14, 20)), 10'($urandom)};
            for (int k = 0; k < row_len && left > 0; k++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    w = sfx_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom,
                                             $urandom});
                    w.neg_max = negmax;
                end
                else
                begin
                    for (int i = 0; i < sfx_pkg::LANES; i++)
                        w[148 - 16 * i -: 16] = typical_half();
                    w.neg_max = negmax;
                    w.lane_count = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd8;
                end
                w.last_item = (k == row_len - 1) || (left == 1);
                send_word(w);
                left--;
                // Now and then: let everything drain mid-stream.
                if ($urandom_range(99) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b0;
        cycle_count = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 55;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_emit(1'b1);

        // Directed: field extremes, specials, lane counts, overflow.
        send_word(make_word(16'h0000, 16'h0000, 4'd8, 1'b0));
        send_word(make_word(16'hFFFF, 16'h0000, 4'd8, 1'b0));
        send_word(make_word(16'h7C00, 16'hFC00, 4'd8, 1'b0));
        send_word(make_word(16'hFC00, 16'h0000, 4'd8, 1'b0));
        send_word(make_word(16'h7E00, 16'h0000, 4'd3, 1'b1));
        send_word(make_word(16'h0001, 16'h8001, 4'd8, 1'b0));
        send_word(make_word(16'h7BFF, 16'h0000, 4'd8, 1'b0));
        send_word(make_word(16'h4C00, 16'h0000, 4'd8, 1'b1));
        send_word(make_word(16'hC900, 16'h0000, 4'd0, 1'b0));
        send_word(make_word(16'h3C00, 16'hBC00, 4'd1, 1'b0));
        send_word(make_word(16'h4000, 16'hC400, 4'd9, 1'b0));
        send_word(make_word(16'h5555, 16'hD555, 4'd15, 1'b1));
        send_word(make_word(16'hD800, 16'h0000, 4'd8, 1'b1));
        send_word(make_word(16'h0000, 16'h7BFF, 4'd7, 1'b1));

        // Fill the core: receiver holds off while the sender keeps offering.
        rx_hold_req = 400;
        random_rows(20);
        wait_drained();
        random_rows(180);
        wait_drained();

        tx_idle_pct = 55;
        rx_idle_pct = 15;
        write_emit(1'b0);
        random_rows(200);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_emit(1'b1);
        random_rows(200);
        wait_drained();

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfx_pkg.sv
rtl/sfx_fma.sv
rtl/sfx_lane.sv
rtl/sfx_merge.sv
rtl/fp16_softmax_sum_exp_core.sv
tb/sv/sfx_checker.sv
tb/sv/tb_top.sv
